// ----- hdl/tlpc_pkg.sv -----
// shared types, constants and codes of the tank level pump controller
package tlpc_pkg;

    // moving average depth
    localparam int AVG_TAPS    = 5;
    localparam int TAP_IDX_W   = $clog2(AVG_TAPS);

    // field widths
    localparam int US_W        = 15;
    localparam int TIME_W      = 32;
    localparam int DIST_W      = 17;
    localparam int LEVEL_W     = 17;
    localparam int PCT_W       = 7;
    localparam int ALERT_W     = 3;
    localparam int HEIGHT_W    = 9;
    localparam int RUNTIME_W   = 16;
    localparam int Q8_SHIFT    = 8;

    // configuration port
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;

    // echo time to distance: floor(us * 4457 / 1024) in 1/256 cm
    localparam int SPEED_NUM   = 4457;
    localparam int SPEED_W     = 13;
    localparam int SPEED_SHIFT = 10;
    localparam int RAW_PROD_W  = US_W + SPEED_W;
    localparam int RAW_W       = RAW_PROD_W - SPEED_SHIFT;
    localparam int MIN_DIST_Q8 = 512;
    localparam int MAX_DIST_Q8 = 102400;

    // running sum and division by the tap count through a reciprocal
    localparam int SUM_W       = DIST_W + $clog2(AVG_TAPS);
    localparam int RECIP_SHIFT = SUM_W + $clog2(AVG_TAPS);
    localparam int RECIP_W     = SUM_W + 2;
    localparam longint unsigned RECIP =
        ((64'd1 << RECIP_SHIFT) + 64'(AVG_TAPS) - 64'd1) / 64'(AVG_TAPS);
    localparam int PROD_W      = SUM_W + RECIP_W;

    // percent division
    localparam int PCT_SCALE   = 100;
    localparam int SCALED_W    = LEVEL_W + PCT_W;
    localparam int PCT_IDX_W   = $clog2(PCT_W);

    // command queue between front and back
    localparam int CMD_DEPTH   = 2;
    localparam int CMD_PTR_W   = $clog2(CMD_DEPTH);
    localparam int CMD_CNT_W   = $clog2(CMD_DEPTH + 1);

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TANK_HEIGHT = 3'd0,
        CFG_LOW_LEVEL   = 3'd1,
        CFG_FULL_LEVEL  = 3'd2,
        CFG_MIN_RUNTIME = 3'd3,
        CFG_MANUAL_MODE = 3'd4,
        CFG_MANUAL_PUMP = 3'd5
    } tlpc_cfg_idx_t;

    // alert codes
    typedef enum logic [ALERT_W-1:0] {
        ALERT_NORMAL     = 3'd0,
        ALERT_CRITICAL   = 3'd1,
        ALERT_FULL       = 3'd2,
        ALERT_MANUAL_OFF = 3'd3,
        ALERT_MANUAL_ON  = 3'd4
    } tlpc_alert_t;

    // back end sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FILTER,
        ST_AVG,
        ST_AVG_DONE,
        ST_LEVEL,
        ST_SCALE,
        ST_DIVIDE,
        ST_DECIDE
    } tlpc_state_t;

    // configuration register set
    typedef struct packed {
        logic [HEIGHT_W-1:0]  tank_height_cm;
        logic [HEIGHT_W-1:0]  low_level_cm;
        logic [HEIGHT_W-1:0]  full_level_cm;
        logic [RUNTIME_W-1:0] min_runtime_ms;
        logic                 manual_mode;
        logic                 manual_pump_on;
    } tlpc_cfg_t;

    // classified sample handed from front to back
    typedef struct packed {
        logic [DIST_W-1:0] raw;
        logic              bad;
        logic [TIME_W-1:0] now;
    } tlpc_cmd_t;

    // one result beat
    typedef struct packed {
        logic [DIST_W-1:0]  filtered_distance;
        logic [LEVEL_W-1:0] water_level;
        logic [PCT_W-1:0]   level_percent;
        logic               pump_running;
        logic               pump_switched;
        tlpc_alert_t        alarm_code;
    } tlpc_result_t;

endpackage

// ----- hdl/tlpc_front.sv -----
// front end: takes echo beats, converts to distance and flags implausible samples
module tlpc_front
    import tlpc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  logic [US_W-1:0]   echo_duration_us,
    input  logic [TIME_W-1:0] now_ms,
    output logic              cmd_push,
    output tlpc_cmd_t         cmd_data,
    input  logic              cmd_full
);

    logic                  stage_valid_reg;
    logic                  stage_valid_next;
    logic [RAW_PROD_W-1:0] stage_prod_reg;
    logic [TIME_W-1:0]     stage_now_reg;
    logic                  stage_zero_reg;
    logic                  accept;
    logic [RAW_W-1:0]      raw;

    // stage is busy only while the queue cannot take its beat
    assign full     = stage_valid_reg & cmd_full;
    assign accept   = push & ~full;
    assign cmd_push = stage_valid_reg & ~cmd_full;

    assign stage_valid_next = accept | (stage_valid_reg & cmd_full);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
        end
    end

    // echo time times speed of sound, captured at accept
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            stage_prod_reg <= RAW_PROD_W'(echo_duration_us) * RAW_PROD_W'(SPEED_NUM);
            stage_now_reg  <= now_ms;
            stage_zero_reg <= (echo_duration_us == '0);
        end
    end

    // range check on the scaled distance
    assign raw = stage_prod_reg[RAW_PROD_W-1:SPEED_SHIFT];

    always_comb
    begin
        cmd_data.raw = raw[DIST_W-1:0];
        cmd_data.now = stage_now_reg;
        cmd_data.bad = stage_zero_reg
                     || (raw < RAW_W'(MIN_DIST_Q8))
                     || (raw > RAW_W'(MAX_DIST_Q8));
    end

endmodule

// ----- hdl/tlpc_cmd_queue.sv -----
// short queue of classified samples between front and back
module tlpc_cmd_queue
    import tlpc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      wr_en,
    input  tlpc_cmd_t wr_data,
    output logic      full,
    input  logic      rd_en,
    output tlpc_cmd_t rd_data,
    output logic      empty
);

    tlpc_cmd_t              entry_reg [CMD_DEPTH];
    logic [CMD_PTR_W-1:0]   wr_ptr_reg;
    logic [CMD_PTR_W-1:0]   wr_ptr_next;
    logic [CMD_PTR_W-1:0]   rd_ptr_reg;
    logic [CMD_PTR_W-1:0]   rd_ptr_next;
    logic [CMD_CNT_W-1:0]   count_reg;
    logic [CMD_CNT_W-1:0]   count_next;
    logic                   do_wr;
    logic                   do_rd;

    assign full    = (count_reg == CMD_CNT_W'(CMD_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en & ~full;
    assign do_rd   = rd_en & ~empty;
    assign rd_data = entry_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == CMD_PTR_W'(CMD_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == CMD_PTR_W'(CMD_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// ----- hdl/tlpc_back.sv -----
// back end: moving average, level, percent divide and pump decision
module tlpc_back
    import tlpc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  tlpc_cfg_t    cfg,
    input  logic         cmd_empty,
    input  tlpc_cmd_t    cmd_data,
    output logic         cmd_pop,
    output tlpc_result_t result,
    output logic         res_empty,
    input  logic         res_pop
);

    tlpc_state_t          state_reg;
    tlpc_state_t          state_next;

    tlpc_cmd_t            cmd_reg;
    logic [DIST_W-1:0]    ring_reg [AVG_TAPS];
    logic [SUM_W-1:0]     sum_reg;
    logic [TAP_IDX_W-1:0] ptr_reg;
    logic                 primed_reg;
    logic [DIST_W-1:0]    dist_reg;
    logic [PROD_W-1:0]    prod_reg;
    logic [LEVEL_W-1:0]   level_reg;
    logic [SCALED_W-1:0]  rem_reg;
    logic [PCT_W-1:0]     quot_reg;
    logic [PCT_IDX_W-1:0] cnt_reg;
    logic                 pump_reg;
    logic [TIME_W-1:0]    switch_time_reg;
    tlpc_result_t         res_reg;
    logic                 res_valid_reg;

    logic                 slot_free;
    logic                 res_load;
    logic [DIST_W-1:0]    sample;
    logic [LEVEL_W-1:0]   height_q8;
    logic [LEVEL_W-1:0]   low_q8;
    logic [LEVEL_W-1:0]   full_q8;
    logic [SCALED_W-1:0]  divisor_shift;
    logic [TIME_W-1:0]    elapsed;
    logic                 want;
    tlpc_alert_t          alert;
    logic [PCT_W-1:0]     percent;

    assign slot_free = ~res_valid_reg | res_pop;
    assign res_empty = ~res_valid_reg;
    assign result    = res_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:     if (!cmd_empty) state_next = ST_FILTER;
            ST_FILTER:   state_next = primed_reg ? ST_AVG : ST_LEVEL;
            ST_AVG:      state_next = ST_AVG_DONE;
            ST_AVG_DONE: state_next = ST_LEVEL;
            ST_LEVEL:    state_next = ST_SCALE;
            ST_SCALE:    state_next = ST_DIVIDE;
            ST_DIVIDE:   if (cnt_reg == '0) state_next = ST_DECIDE;
            ST_DECIDE:   if (slot_free) state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        cmd_pop  = 1'b0;
        res_load = 1'b0;
        case (state_reg)
            ST_IDLE:   cmd_pop  = ~cmd_empty;
            ST_DECIDE: res_load = slot_free;
            default:
            begin
                cmd_pop  = 1'b0;
                res_load = 1'b0;
            end
        endcase
    end

    // datapath helpers
    assign sample        = cmd_reg.bad ? dist_reg : cmd_reg.raw;
    assign height_q8     = {cfg.tank_height_cm, {Q8_SHIFT{1'b0}}};
    assign low_q8        = {cfg.low_level_cm, {Q8_SHIFT{1'b0}}};
    assign full_q8       = {cfg.full_level_cm, {Q8_SHIFT{1'b0}}};
    assign divisor_shift = SCALED_W'(height_q8) << cnt_reg;
    assign elapsed       = cmd_reg.now - switch_time_reg;
    assign percent       = (height_q8 == '0) ? '0 : quot_reg;

    // pump decision: manual command or hysteresis with minimum on-time
    always_comb
    begin
        want  = pump_reg;
        alert = ALERT_NORMAL;
        if (cfg.manual_mode)
        begin
            want  = cfg.manual_pump_on;
            alert = cfg.manual_pump_on ? ALERT_MANUAL_ON : ALERT_MANUAL_OFF;
        end
        else
        begin
            if (level_reg <= low_q8)
            begin
                want  = 1'b1;
                alert = ALERT_CRITICAL;
            end
            else if (level_reg >= full_q8)
            begin
                want  = 1'b0;
                alert = ALERT_FULL;
            end
            if (pump_reg && !want && (elapsed < TIME_W'(cfg.min_runtime_ms)))
            begin
                want = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            for (int i = 0; i < AVG_TAPS; i++)
            begin
                ring_reg[i] <= '0;
            end
            sum_reg         <= '0;
            ptr_reg         <= '0;
            primed_reg      <= 1'b0;
            dist_reg        <= '0;
            pump_reg        <= 1'b0;
            switch_time_reg <= '0;
            res_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            // moving average ring, filled whole by the first sample
            if (state_reg == ST_FILTER)
            begin
                if (!primed_reg)
                begin
                    for (int i = 0; i < AVG_TAPS; i++)
                    begin
                        ring_reg[i] <= sample;
                    end
                    sum_reg    <= SUM_W'(sample) * SUM_W'(AVG_TAPS);
                    primed_reg <= 1'b1;
                    dist_reg   <= sample;
                end
                else
                begin
                    sum_reg           <= sum_reg - SUM_W'(ring_reg[ptr_reg]) + SUM_W'(sample);
                    ring_reg[ptr_reg] <= sample;
                    ptr_reg           <= (ptr_reg == TAP_IDX_W'(AVG_TAPS - 1)) ?
                                         '0 : ptr_reg + 1'b1;
                end
            end

            // average out of the reciprocal product
            if (state_reg == ST_AVG_DONE)
            begin
                dist_reg <= DIST_W'(prod_reg >> RECIP_SHIFT);
            end

            // pump state and switch time
            if (res_load)
            begin
                pump_reg <= want;
                if (want != pump_reg)
                begin
                    switch_time_reg <= cmd_reg.now;
                end
            end

            // result register
            if (res_load)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res_pop)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd_pop)
        begin
            cmd_reg <= cmd_data;
        end

        if (state_reg == ST_AVG)
        begin
            prod_reg <= PROD_W'(sum_reg) * PROD_W'(RECIP);
        end

        // clamped level
        if (state_reg == ST_LEVEL)
        begin
            level_reg <= (dist_reg >= height_q8) ? '0 : height_q8 - dist_reg;
        end

        // restoring divide of level*100 by height, one quotient bit per beat
        if (state_reg == ST_SCALE)
        begin
            rem_reg  <= SCALED_W'(level_reg) * SCALED_W'(PCT_SCALE);
            quot_reg <= '0;
            cnt_reg  <= PCT_IDX_W'(PCT_W - 1);
        end
        else if (state_reg == ST_DIVIDE)
        begin
            if (rem_reg >= divisor_shift)
            begin
                rem_reg           <= rem_reg - divisor_shift;
                quot_reg[cnt_reg] <= 1'b1;
            end
            cnt_reg <= cnt_reg - 1'b1;
        end

        if (res_load)
        begin
            res_reg.filtered_distance <= dist_reg;
            res_reg.water_level       <= level_reg;
            res_reg.level_percent     <= percent;
            res_reg.pump_running      <= want;
            res_reg.pump_switched     <= (want != pump_reg);
            res_reg.alarm_code        <= alert;
        end
    end

endmodule

// ----- hdl/tank_level_pump_controller_top.sv -----
// top level of the tank level pump controller
//
// Input channel: push with echo_duration_us and now_ms, accepted when push is
// high and full is low. Result channel: empty low shows the oldest result on
// the result ports; pop takes it. Configuration: cfg_valid, cfg_index and
// cfg_data write one register per beat; cfg_ready is always high, and writes
// are meant for times when no sample is in flight.
// The front stage registers the echo product and flags timeouts and out of
// range distances; a two-entry queue feeds the back sequencer.
// The back sequencer handles one sample at a time and waits in its decide
// state while the result register is full. Its pace is set by the 7-step
// percent divider and by the reciprocal multiply for the moving average,
// a multiply that the very first sample skips as it fills the ring whole.
// A result waits in the output register while pop is low; meanwhile the
// front and queue keep taking up to three more samples before full rises.
// Reset clears the ring, running sum, pump state and switch time, and loads
// the register defaults: height 100 cm, low 20 cm, full 90 cm, 10000 ms.
module tank_level_pump_controller_top
    import tlpc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    output logic                  full,
    input  logic [US_W-1:0]       echo_duration_us,
    input  logic [TIME_W-1:0]     now_ms,
    output logic                  empty,
    input  logic                  pop,
    output logic [DIST_W-1:0]     filtered_distance,
    output logic [LEVEL_W-1:0]    water_level,
    output logic [PCT_W-1:0]      level_percent,
    output logic                  pump_running,
    output logic                  pump_switched,
    output logic [ALERT_W-1:0]    alarm_code,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    tlpc_cfg_t    cfg_reg;
    tlpc_cmd_t    front_cmd;
    tlpc_cmd_t    queue_cmd;
    tlpc_result_t result;
    logic         front_push;
    logic         queue_full;
    logic         queue_empty;
    logic         queue_pop;

    assign cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.tank_height_cm <= HEIGHT_W'(100);
            cfg_reg.low_level_cm   <= HEIGHT_W'(20);
            cfg_reg.full_level_cm  <= HEIGHT_W'(90);
            cfg_reg.min_runtime_ms <= RUNTIME_W'(10000);
            cfg_reg.manual_mode    <= 1'b0;
            cfg_reg.manual_pump_on <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (tlpc_cfg_idx_t'(cfg_index))
                CFG_TANK_HEIGHT: cfg_reg.tank_height_cm <= cfg_data[HEIGHT_W-1:0];
                CFG_LOW_LEVEL:   cfg_reg.low_level_cm   <= cfg_data[HEIGHT_W-1:0];
                CFG_FULL_LEVEL:  cfg_reg.full_level_cm  <= cfg_data[HEIGHT_W-1:0];
                CFG_MIN_RUNTIME: cfg_reg.min_runtime_ms <= cfg_data[RUNTIME_W-1:0];
                CFG_MANUAL_MODE: cfg_reg.manual_mode    <= cfg_data[0];
                CFG_MANUAL_PUMP: cfg_reg.manual_pump_on <= cfg_data[0];
                default:         cfg_reg                <= cfg_reg;
            endcase
        end
    end

    // front: conversion and classification
    tlpc_front u_front (
        .clk              (clk),
        .rst_n            (rst_n),
        .push             (push),
        .full             (full),
        .echo_duration_us (echo_duration_us),
        .now_ms           (now_ms),
        .cmd_push         (front_push),
        .cmd_data         (front_cmd),
        .cmd_full         (queue_full)
    );

    // queue between front and back
    tlpc_cmd_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (front_push),
        .wr_data (front_cmd),
        .full    (queue_full),
        .rd_en   (queue_pop),
        .rd_data (queue_cmd),
        .empty   (queue_empty)
    );

    // back: filter, level and pump control
    tlpc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .cmd_empty (queue_empty),
        .cmd_data  (queue_cmd),
        .cmd_pop   (queue_pop),
        .result    (result),
        .res_empty (empty),
        .res_pop   (pop)
    );

    assign filtered_distance = result.filtered_distance;
    assign water_level       = result.water_level;
    assign level_percent     = result.level_percent;
    assign pump_running      = result.pump_running;
    assign pump_switched     = result.pump_switched;
    assign alarm_code        = result.alarm_code;

endmodule

// ----- tb/tlpc_level_checker.sv -----
// result checker for the tank level pump controller: predicts every reading and compares
module tlpc_level_checker
    import tlpc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  logic                  full,
    input  logic [US_W-1:0]       echo_duration_us,
    input  logic [TIME_W-1:0]     now_ms,
    input  logic                  empty,
    input  logic                  pop,
    input  logic [DIST_W-1:0]     filtered_distance,
    input  logic [LEVEL_W-1:0]    water_level,
    input  logic [PCT_W-1:0]      level_percent,
    input  logic                  pump_running,
    input  logic                  pump_switched,
    input  logic [ALERT_W-1:0]    alarm_code,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int unsigned           mismatch_count,
    output int unsigned           readings_owed
);

    // averaging depth, echo scale and plausible distance window in 1/256 cm
    localparam int unsigned TAPS      = 5;
    localparam int unsigned ECHO_NUM  = 4457;
    localparam int unsigned NEAR_Q8   = 512;
    localparam int unsigned FAR_Q8    = 102400;
    localparam int unsigned MAX_SHOWN = 10;

    // register copies
    logic [31:0] height_cm;
    logic [31:0] low_cm;
    logic [31:0] full_cm;
    logic [31:0] runtime_ms;
    bit          manual;
    bit          manual_on;

    // filter and pump state
    logic [31:0] ring [TAPS];
    logic [31:0] sum_q8;
    int unsigned ring_ptr;
    bit          primed;
    logic [31:0] prev_dist;
    bit          pump_on;
    logic [31:0] switched_at;

    tlpc_result_t owed_readings[$];
    int unsigned  mismatches = 0;

    task automatic reset_model();
        height_cm   = 100;
        low_cm      = 20;
        full_cm     = 90;
        runtime_ms  = 10000;
        manual      = 1'b0;
        manual_on   = 1'b0;
        foreach (ring[i])
            ring[i] = '0;
        sum_q8      = '0;
        ring_ptr    = 0;
        primed      = 1'b0;
        prev_dist   = '0;
        pump_on     = 1'b0;
        switched_at = '0;
    endtask

    // one sample through converter, average, level and pump decision
    function automatic tlpc_result_t next_reading(input logic [US_W-1:0] us,
                                                  input logic [TIME_W-1:0] t);
        logic [31:0]  raw;
        logic [31:0]  sample;
        logic [31:0]  avg_q8;
        logic [31:0]  height;
        logic [31:0]  level;
        logic [31:0]  pct;
        bit           want;
        bit           flipped;
        tlpc_alert_t  alert;
        tlpc_result_t r;

        raw = (32'(us) * ECHO_NUM) >> 10;
        if (us == '0 || raw < NEAR_Q8 || raw > FAR_Q8)
            sample = prev_dist;
        else
            sample = raw;

        // first sample fills the whole ring
        if (!primed)
        begin
            foreach (ring[i])
                ring[i] = sample;
            sum_q8 = sample * TAPS;
            primed = 1'b1;
            avg_q8 = sample;
        end
        else
        begin
            if (ring_ptr >= TAPS)
                ring_ptr = 0;
            sum_q8         = sum_q8 - ring[ring_ptr] + sample;
            ring[ring_ptr] = sample;
            ring_ptr       = (ring_ptr + 1) % TAPS;
            avg_q8         = sum_q8 / TAPS;
        end
        prev_dist = avg_q8;

        height = height_cm << 8;
        level  = (avg_q8 >= height) ? 32'd0 : height - avg_q8;
        pct    = (height == 0) ? 32'd0 : (level * 100) / height;

        // hysteresis, or the manual command
        if (manual)
        begin
            want  = manual_on;
            alert = want ? ALERT_MANUAL_ON : ALERT_MANUAL_OFF;
        end
        else
        begin
            if (level <= (low_cm << 8))
            begin
                want  = 1'b1;
                alert = ALERT_CRITICAL;
            end
            else if (level >= (full_cm << 8))
            begin
                want  = 1'b0;
                alert = ALERT_FULL;
            end
            else
            begin
                want  = pump_on;
                alert = ALERT_NORMAL;
            end
            // minimum on-time, elapsed time wraps
            if (pump_on && !want && (t - switched_at) < runtime_ms)
                want = 1'b1;
        end

        flipped = 1'b0;
        if (want != pump_on)
        begin
            pump_on     = want;
            switched_at = t;
            flipped     = 1'b1;
        end

        r.filtered_distance = avg_q8[DIST_W-1:0];
        r.water_level       = level[LEVEL_W-1:0];
        r.level_percent     = pct[PCT_W-1:0];
        r.pump_running      = pump_on;
        r.pump_switched     = flipped;
        r.alarm_code        = alert;
        return r;
    endfunction

    task automatic check_field(input string what, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            mismatches++;
            if (mismatches <= MAX_SHOWN)
                $display("mismatch on %s: expected %0d, got %0d", what, want, got);
        end
    endtask

    // config writes, result beats and sample beats in edge order
    always @(posedge clk)
    begin
        tlpc_result_t want_r;

        if (!rst_n)
        begin
            reset_model();
            owed_readings.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (tlpc_cfg_idx_t'(cfg_index))
                    CFG_TANK_HEIGHT: height_cm  = 32'(cfg_data[HEIGHT_W-1:0]);
                    CFG_LOW_LEVEL:   low_cm     = 32'(cfg_data[HEIGHT_W-1:0]);
                    CFG_FULL_LEVEL:  full_cm    = 32'(cfg_data[HEIGHT_W-1:0]);
                    CFG_MIN_RUNTIME: runtime_ms = 32'(cfg_data[RUNTIME_W-1:0]);
                    CFG_MANUAL_MODE: manual     = cfg_data[0];
                    CFG_MANUAL_PUMP: manual_on  = cfg_data[0];
                    default: ;
                endcase
            end

            if (pop && !empty)
            begin
                if (owed_readings.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= MAX_SHOWN)
                        $display("result beat with no sample outstanding");
                end
                else
                begin
                    want_r = owed_readings.pop_front();
                    check_field("filtered_distance", 32'(want_r.filtered_distance),
                                32'(filtered_distance));
                    check_field("water_level", 32'(want_r.water_level), 32'(water_level));
                    check_field("level_percent", 32'(want_r.level_percent),
                                32'(level_percent));
                    check_field("pump_running", 32'(want_r.pump_running),
                                32'(pump_running));
                    check_field("pump_switched", 32'(want_r.pump_switched),
                                32'(pump_switched));
                    check_field("alarm_code", 32'(want_r.alarm_code),
                                32'(alarm_code));
                end
            end

            if (push && !full)
                owed_readings.push_back(next_reading(echo_duration_us, now_ms));
        end

        mismatch_count <= mismatches;
        readings_owed  <= owed_readings.size();
    end

endmodule

// ----- tb/tank_level_pump_controller_top_tb.sv -----
// stimulus and verdict for the tank level pump controller
module tank_level_pump_controller_top_tb;
    import tlpc_pkg::*;

    typedef struct {
        int unsigned height;
        int unsigned low;
        int unsigned full;
        int unsigned runtime;
        bit          manual;
        bit          manual_on;
    } pump_setup_t;

    localparam int          PHASES      = 12;
    localparam int          PHASE_ITEMS = 90;
    localparam int          FIXED_SETUPS = 8;

    // corner settings: defaults with no hold, longest hold, tiny and zero tank,
    // thresholds at the tank top, manual on and off, zero thresholds
    pump_setup_t setup_list [FIXED_SETUPS] = '{
        '{100, 20, 90, 0, 1'b0, 1'b0},
        '{400, 50, 350, 65535, 1'b0, 1'b0},
        '{1, 0, 1, 100, 1'b0, 1'b0},
        '{0, 0, 0, 3000, 1'b0, 1'b0},
        '{511, 511, 511, 10000, 1'b0, 1'b0},
        '{200, 80, 150, 500, 1'b1, 1'b1},
        '{200, 80, 150, 500, 1'b1, 1'b0},
        '{300, 0, 0, 1000, 1'b0, 1'b0}
    };

    logic                  clk;
    logic                  rst_n;
    logic                  push;
    logic                  full;
    logic [US_W-1:0]       echo_duration_us;
    logic [TIME_W-1:0]     now_ms;
    logic                  empty;
    logic                  pop;
    logic [DIST_W-1:0]     filtered_distance;
    logic [LEVEL_W-1:0]    water_level;
    logic [PCT_W-1:0]      level_percent;
    logic                  pump_running;
    logic                  pump_switched;
    logic [ALERT_W-1:0]    alarm_code;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    int unsigned           mismatch_count;
    int unsigned           readings_owed;

    bit                    quiet;
    int unsigned           stall_left;
    logic [TIME_W-1:0]     clock_ms;

    tank_level_pump_controller_top u_top (.*);

    tlpc_level_checker u_checker (.*);

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // run limit
    initial
    begin
        #5_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    // result side back-pressure in bursts
    always @(posedge clk)
    begin
        if (stall_left != 0)
        begin
            stall_left--;
            pop <= 1'b0;
        end
        else if (!quiet && $urandom_range(0, 11) == 0)
        begin
            stall_left = $urandom_range(1, 18) - 1;
            pop <= 1'b0;
        end
        else
            pop <= 1'b1;
    end

    // echo width for a surface distance in whole cm
    function automatic logic [US_W-1:0] us_for_cm(input int cm);
        return US_W'((cm * 262144) / 4457);
    endfunction

    // one sample beat, push stays high on return
    task automatic send_sample(input logic [US_W-1:0] us, input logic [TIME_W-1:0] t);
        push             <= 1'b1;
        echo_duration_us <= us;
        now_ms           <= t;
        do
            @(posedge clk);
        while (full);
    endtask

    // one register beat, valid stays high on return
    task automatic write_reg(input tlpc_cfg_idx_t idx, input int unsigned value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_W'(value);
        do
            @(posedge clk);
        while (!cfg_ready);
    endtask

    // hold the sender until every reading is back
    task automatic wait_all_done();
        push <= 1'b0;
        do
            @(posedge clk);
        while (readings_owed != 0);
    endtask

    initial
    begin
        pump_setup_t       s;
        int                surface_cm;
        int                surface_dir;
        int                span;
        int unsigned       pick;
        logic [US_W-1:0]   us;

        rst_n            = 1'b0;
        push             = 1'b0;
        echo_duration_us = '0;
        now_ms           = '0;
        pop              = 1'b0;
        cfg_valid        = 1'b0;
        cfg_index        = CFG_TANK_HEIGHT;
        cfg_data         = '0;
        quiet            = 1'b0;
        stall_left       = 0;
        clock_ms         = '0;
        surface_cm       = 50;
        surface_dir      = 1;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // timeout as first sample, range edges and field extremes
        send_sample('0, 0);
        send_sample(118, 100);
        send_sample(117, 200);
        send_sample(23526, 300);
        send_sample(23527, 400);
        send_sample(30000, 500);
        send_sample(US_W'(32767), 600);
        send_sample(16384, 700);
        send_sample(1, 800);
        send_sample('0, 900);

        // drain the tank, refill within the minimum on-time, then past it
        clock_ms = 1000;
        repeat (4)
        begin
            clock_ms += 100;
            send_sample(us_for_cm(95), clock_ms);
        end
        repeat (3)
        begin
            clock_ms += 100;
            send_sample(us_for_cm(5), clock_ms);
        end
        clock_ms += 20000;
        send_sample(us_for_cm(5), clock_ms);

        // on-time measured across the timestamp wrap
        clock_ms = 32'hFFFF_F000;
        repeat (4)
            send_sample(us_for_cm(95), clock_ms);
        clock_ms = 32'h0000_0800;
        repeat (3)
            send_sample(us_for_cm(5), clock_ms);
        clock_ms += 8000;
        send_sample(us_for_cm(5), clock_ms);
        wait_all_done();

        for (int p = 0; p < PHASES; p++)
        begin
            if (p < FIXED_SETUPS)
                s = setup_list[p];
            else
            begin
                s.height    = $urandom_range(1, 511);
                s.low       = $urandom_range(0, (s.height > 400) ? 400 : s.height);
                s.full      = $urandom_range(s.low, 511);
                s.runtime   = $urandom_range(0, 65535);
                s.manual    = ($urandom_range(0, 3) == 0);
                s.manual_on = $urandom_range(0, 1);
            end

            // registers only change with nothing in flight
            write_reg(CFG_TANK_HEIGHT, s.height);
            write_reg(CFG_LOW_LEVEL, s.low);
            write_reg(CFG_FULL_LEVEL, s.full);
            write_reg(CFG_MIN_RUNTIME, s.runtime);
            write_reg(CFG_MANUAL_MODE, s.manual);
            write_reg(CFG_MANUAL_PUMP, s.manual_on);
            cfg_valid <= 1'b0;
            quiet     <= (p == 3 || p == 7 || p >= PHASES - 2);

            span = (s.height >= 10 && s.height <= 400) ? s.height : 400;
            if (surface_cm > span)
                surface_cm = span;

            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                // sender gap
                if (!quiet && $urandom_range(0, 5) == 0)
                begin
                    push <= 1'b0;
                    repeat ($urandom_range(1, 18)) @(posedge clk);
                end

                // mostly a wandering surface, some timeouts and junk echoes
                pick = $urandom_range(0, 99);
                if (pick < 75)
                begin
                    surface_cm += surface_dir * int'($urandom_range(0, 12));
                    if (surface_cm <= 2)
                    begin
                        surface_cm  = 2;
                        surface_dir = 1;
                    end
                    else if (surface_cm >= span)
                    begin
                        surface_cm  = span;
                        surface_dir = -1;
                    end
                    if ($urandom_range(0, 19) == 0)
                        surface_dir = -surface_dir;
                    us = us_for_cm(surface_cm) + US_W'($urandom_range(0, 58));
                end
                else if (pick < 85)
                    us = '0;
                else if (pick < 95)
                begin
                    if ($urandom_range(0, 1) == 0)
                        us = US_W'($urandom_range(1, 117));
                    else
                        us = US_W'($urandom_range(23527, 32767));
                end
                else
                    us = US_W'($urandom_range(0, 32767));

                // timestamps mostly creep, sometimes jump or land anywhere
                pick = $urandom_range(0, 99);
                if (pick < 90)
                    clock_ms += $urandom_range(0, 600);
                else if (pick < 97)
                    clock_ms += $urandom_range(5000, 70000);
                else
                    clock_ms = $urandom;

                send_sample(us, clock_ms);
            end
            wait_all_done();
        end

        repeat (30) @(posedge clk);
        if (mismatch_count == 0 && readings_owed == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ----- files.f -----
hdl/tlpc_pkg.sv
hdl/tlpc_front.sv
hdl/tlpc_cmd_queue.sv
hdl/tlpc_back.sv
hdl/tank_level_pump_controller_top.sv
tb/tlpc_level_checker.sv
tb/tank_level_pump_controller_top_tb.sv
